// File: rtl/plc_pkg.sv
// Package for the password lexical checker: verdict codes, class flag
// positions, register indexes and the structs shared between modules.
// No dependencies.
`default_nettype none

package plc_pkg;

   localparam int unsigned CHAR_WIDTH      = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned CLASS_COUNT     = 5;

   // Class flag bit positions
   localparam int unsigned CL_UPPER = 0;
   localparam int unsigned CL_LOWER = 1;
   localparam int unsigned CL_CTRL  = 2;
   localparam int unsigned CL_DIGIT = 3;
   localparam int unsigned CL_PUNCT = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TILDE = 8'h7E;

   typedef enum logic [1:0] {
      VERDICT_OK      = 2'd0,
      VERDICT_SHORT   = 2'd1,
      VERDICT_RUN     = 2'd2,
      VERDICT_ILLEGAL = 2'd3
   } verdict_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_CHARS         = 3'd0,
      CSR_MAX_RUN           = 3'd1,
      CSR_PRINTABLE_ONLY    = 3'd2,
      CSR_ALLOW_SINGLE_CASE = 3'd3,
      CSR_FORBIDDEN_MASK    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  min_chars;
      logic [7:0]  max_run;
      logic        printable_only;
      logic        allow_single_case;
      logic [31:0] forbidden_control_mask;
   } cfg_type;

   typedef struct packed {
      logic [CLASS_COUNT-1:0] class_flags;
      logic                   illegal;
   } byte_info_type;

endpackage

`default_nettype wire

// File: rtl/plc_byte_check.sv
// Per-byte classifier: character class and illegal-byte decision.
// Depends on plc_pkg.
`default_nettype none

module plc_byte_check
   import plc_pkg::*;
(
   input  wire logic [CHAR_WIDTH-1:0] char_code,
   input  wire cfg_type               cfg,
   output byte_info_type              info
);

   logic nonprint;

   always_comb begin
      nonprint = (char_code < CHAR_SPACE) || (char_code > CHAR_TILDE);
      info = '0;
      // Only control bytes below the space can be forbidden by the mask.
      info.illegal = nonprint && (cfg.printable_only ||
                     ((char_code < CHAR_SPACE) && cfg.forbidden_control_mask[char_code[4:0]]));
      priority if (nonprint) begin
         info.class_flags[CL_CTRL] = 1'b1;
      end else if (char_code >= 8'h41 && char_code <= 8'h5A) begin
         info.class_flags[CL_UPPER] = 1'b1;
      end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
         info.class_flags[CL_LOWER] = 1'b1;
      end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
         info.class_flags[CL_DIGIT] = 1'b1;
      end else if (char_code != CHAR_SPACE) begin
         info.class_flags[CL_PUNCT] = 1'b1;
      end else begin
         // a space sets no class
         info.class_flags = '0;
      end
   end

endmodule

`default_nettype wire

// File: rtl/plc_track.sv
// Password state: length, run tracking, class flags, latched failure,
// and the end-of-password verdict. Depends on plc_pkg.
`default_nettype none

module plc_track
   import plc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  finish,
   input  wire logic [CHAR_WIDTH-1:0] char_code,
   input  wire byte_info_type         info,
   input  wire cfg_type               cfg,
   output verdict_type                verdict
);

   localparam int unsigned CmpWidth = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

   logic [COUNT_WIDTH-1:0] length_count_ff, length_count_in;
   logic [COUNT_WIDTH-1:0] run_count_ff, run_count_in;
   logic [CHAR_WIDTH-1:0]  previous_byte_ff, previous_byte_in;
   logic [CLASS_COUNT-1:0] class_flags_ff, class_flags_in;
   verdict_type            failure_code_ff, failure_code_in;

   logic [COUNT_WIDTH-1:0] run_next;
   logic                   run_fail;

   always_comb begin
      length_count_in  = length_count_ff;
      run_count_in     = run_count_ff;
      previous_byte_in = previous_byte_ff;
      class_flags_in   = class_flags_ff;
      failure_code_in  = failure_code_ff;
      run_next = (run_count_ff == '1) ? run_count_ff : run_count_ff + 1'b1;
      run_fail = (cfg.max_run != '0) &&
                 (CmpWidth'(run_next) >= CmpWidth'(cfg.max_run));
      if (finish) begin
         length_count_in  = '0;
         run_count_in     = '0;
         previous_byte_in = '0;
         class_flags_in   = '0;
         failure_code_in  = VERDICT_OK;
      end else if (step) begin
         if (length_count_ff != '1) begin
            length_count_in = length_count_ff + 1'b1;
         end
         // Once a failure is latched only the length keeps counting.
         if (failure_code_ff == VERDICT_OK) begin
            if (char_code != previous_byte_ff) begin
               previous_byte_in = char_code;
               run_count_in     = COUNT_WIDTH'(1);
               if (info.illegal) begin
                  failure_code_in = VERDICT_ILLEGAL;
               end else begin
                  class_flags_in = class_flags_ff | info.class_flags;
               end
            end else begin
               run_count_in = run_next;
               if (run_fail) begin
                  failure_code_in = VERDICT_RUN;
               end else if (info.illegal) begin
                  failure_code_in = VERDICT_ILLEGAL;
               end else begin
                  class_flags_in = class_flags_ff | info.class_flags;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_count_ff  <= '0;
         run_count_ff     <= '0;
         previous_byte_ff <= '0;
         class_flags_ff   <= '0;
         failure_code_ff  <= VERDICT_OK;
      end else begin
         length_count_ff  <= length_count_in;
         run_count_ff     <= run_count_in;
         previous_byte_ff <= previous_byte_in;
         class_flags_ff   <= class_flags_in;
         failure_code_ff  <= failure_code_in;
      end
   end

   always_comb begin
      if ((cfg.min_chars != '0) &&
          (CmpWidth'(length_count_ff) < CmpWidth'(cfg.min_chars))) begin
         verdict = VERDICT_SHORT;
      end else if (failure_code_ff != VERDICT_OK) begin
         verdict = failure_code_ff;
      end else if (class_flags_ff[CL_UPPER] && class_flags_ff[CL_LOWER]) begin
         verdict = VERDICT_OK;
      end else if (class_flags_ff[CL_DIGIT] || class_flags_ff[CL_PUNCT] ||
                   class_flags_ff[CL_CTRL]) begin
         verdict = VERDICT_OK;
      end else if (cfg.allow_single_case) begin
         verdict = VERDICT_OK;
      end else begin
         verdict = VERDICT_ILLEGAL;
      end
   end

endmodule

`default_nettype wire

// File: rtl/password_lexical_checker.sv
// Top level of the password lexical checker: input word register, config
// registers and the verdict output register. Depends on plc_pkg,
// plc_byte_check and plc_track.
//
// Usage:
//  - Send the password one byte per word on req_char_code (req_valid /
//    req_stall). A zero byte ends the password; it yields exactly one
//    verdict word on rsp_verdict (rsp_valid / rsp_stall). Other bytes
//    yield nothing.
//  - Verdict: 0 ok, 1 too short, 2 repeated run, 3 illegal or single-case.
//  - An accepted zero byte passes the input register, then the verdict register.
//  - Throughput: one byte per cycle while req_stall is low: input register,
//    then classify/update logic into the state and verdict registers.
//  - A pending verdict that the receiver stalls is held in the output
//    register; further non-zero bytes keep flowing. req_stall rises only
//    when a zero byte waits behind a stalled verdict.
//  - Configuration: csr_valid / csr_ready (always ready), csr_index picks
//    the register, csr_wdata carries the value. Write only while idle.
//  - Reset (synchronous, active high) clears the config registers, the password
//    state and both valid flags, not the data registers; no clearing pass is needed.
`default_nettype none

module password_lexical_checker
   import plc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input words
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [CHAR_WIDTH-1:0]      req_char_code,
   // verdict words
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_verdict,
   // config writes
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_char_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_verdict_ff;

   logic          in_accept;
   logic          in_is_end;
   logic          blocked;
   logic          advance;
   logic          step;
   logic          finish;
   byte_info_type info;
   verdict_type   verdict;

   // Config registers: always ready, decode the index.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_CHARS:         cfg_in.min_chars = csr_wdata[7:0];
            CSR_MAX_RUN:           cfg_in.max_run = csr_wdata[7:0];
            CSR_PRINTABLE_ONLY:    cfg_in.printable_only = csr_wdata[0];
            CSR_ALLOW_SINGLE_CASE: cfg_in.allow_single_case = csr_wdata[0];
            CSR_FORBIDDEN_MASK:    cfg_in.forbidden_control_mask = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register. Hold an end byte only while the verdict slot is
   // occupied and stalled; everything else advances every cycle.
   assign in_is_end = (in_char_ff == '0);
   assign blocked   = in_valid_ff && in_is_end && rsp_valid_ff && rsp_stall;
   assign advance   = in_valid_ff && !blocked;
   assign step      = advance && !in_is_end;
   assign finish    = advance && in_is_end;
   assign req_stall = blocked;
   assign in_accept = req_valid && !req_stall;

   always_comb begin
      if (in_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         in_char_ff <= req_char_code;
      end
   end

   plc_byte_check u_byte_check (
      .char_code (in_char_ff),
      .cfg       (cfg_ff),
      .info      (info)
   );

   plc_track #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .finish    (finish),
      .char_code (in_char_ff),
      .info      (info),
      .cfg       (cfg_ff),
      .verdict   (verdict)
   );

   // Verdict register: load on an end byte, drop once taken.
   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule

`default_nettype wire

// File: rtl/plc_checker.sv
// Port-level checker for the password lexical checker, bound to its top.
// Depends on plc_pkg and password_lexical_checker.
`default_nettype none

module plc_checker
   import plc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic [CHAR_WIDTH-1:0] req_char_code,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [1:0]            rsp_verdict
);

   // Leave reset with nothing pending on either side.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("verdict valid right after reset");

   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   // Stall input only behind a verdict that the receiver holds off.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked verdict");

   // Hold a stalled verdict.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_verdict)))
      else $error("stalled verdict changed or dropped");

   // Hold a stalled input byte.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_char_code)))
      else $error("stalled input byte changed or dropped");

endmodule

bind password_lexical_checker plc_checker u_plc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_char_code (req_char_code),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_verdict   (rsp_verdict)
);

`default_nettype wire
